// ===== rtl/mpps_pkg.sv =====
// Shared types and constants for the min-plus path squaring block.
package mpps_pkg;
    localparam int MaxNodes = 8;
    localparam int IdxW = 3;
    localparam int Cells = MaxNodes * MaxNodes;
    localparam int AddrW = 6;
    localparam logic [16:0] InfValue = 17'd65536;

    typedef logic [16:0] t_dist;

    // Controls passed from the sequencer into each row cell.
    typedef struct packed {
        logic       clear;    // start a new minimum
        logic       step;     // fold one k term
    } t_cell_ctl;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;
endpackage

// ===== rtl/mpps_cell.sv =====
// One cell of the min-plus chain: holds a running minimum for one output column.
module mpps_cell (
    input  logic                   i_clk,
    input  mpps_pkg::t_cell_ctl    i_ctl,
    input  mpps_pkg::t_dist        i_aik,
    input  mpps_pkg::t_dist        i_bkj,
    output mpps_pkg::t_dist        o_best
);
    mpps_pkg::t_dist r_best;
    logic [17:0] sum;

    assign sum = {1'b0, i_aik} + {1'b0, i_bkj};

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_best <= mpps_pkg::InfValue;
        end else if (i_ctl.step) begin
            if (sum < {1'b0, r_best}) begin
                r_best <= sum[16:0];
            end
        end
    end

    assign o_best = r_best;
endmodule

// ===== rtl/min_plus_path_squaring.sv =====
// Top level of the all-pairs shortest path block using min-plus squaring.
// Usage: write node_count (2..8, saturated) on i_cfg_we/i_cfg_data while idle;
// this restarts loading. Then send n*n weight beats on the input channel in
// row-major order. A zero off the diagonal means no edge; the diagonal is
// always taken as zero.
// After the last weight the block runs ceil(log2(n-1)) squaring passes. Each
// pass walks every row i and every k: a fetch state reads A[i][k] and row k,
// a calc state lets a chain of eight cells (one per column j) fold
// A[i][k]+A[k][j] into its running minimum, and a write state per row writes
// the products back.
// Results then leave as n*n beats in row-major order, unreachable nodes as 0,
// with o_last high on the final beat. Within a row the beats leave one per
// cycle when not stalled; each row first waits for its registered read. A
// receiver stall (i_out_stall) holds the beat in the output register.
// Input is stalled during squaring and emission; loading accepts back-to-back
// beats. Reset sets node_count to 8 and returns to loading; the matrix memory
// needs no clearing since every entry is loaded before it is read.
module min_plus_path_squaring (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_weight,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_distance,
    output logic        o_last
);
    localparam int N = mpps_pkg::MaxNodes;
    localparam int W = mpps_pkg::IdxW;

    mpps_pkg::t_state r_state;
    logic [3:0]     r_ncfg;
    logic [W:0]     nodes;
    logic [W-1:0]   r_row, r_col, r_k;
    logic [2:0]     r_passes;
    logic [2:0]     r_pass;

    // Matrix as rows of N entries; one row read per cycle, and every row written at the end of a pass.
    mpps_pkg::t_dist rowk [N];
    mpps_pkg::t_dist r_aik;
    mpps_pkg::t_dist best [N];
    mpps_pkg::t_cell_ctl ctl;

    logic [N*17-1:0] r_mat [N];

    always_comb begin
        if (r_ncfg < 4'd2) nodes = 4'd2;
        else if (r_ncfg > 4'd8) nodes = 4'd8;
        else nodes = r_ncfg;
    end

    logic [2:0] passes_calc;
    always_comb begin
        if (nodes <= 4'd2) passes_calc = 3'd0;
        else if (nodes <= 4'd3) passes_calc = 3'd1;
        else if (nodes <= 4'd5) passes_calc = 3'd2;
        else passes_calc = 3'd3;
    end

    logic [W-1:0] nlast;
    assign nlast = W'(nodes - 4'd1);

    logic in_acc, out_acc;
    assign o_in_stall = (r_state != mpps_pkg::ST_LOAD);
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    mpps_pkg::t_dist wval;
    always_comb begin
        if (r_row == r_col) wval = '0;
        else if (i_weight == 16'd0) wval = mpps_pkg::InfValue;
        else wval = {1'b0, i_weight};
    end

    assign ctl.clear = (r_state == mpps_pkg::ST_FETCH) && (r_k == '0);
    assign ctl.step = (r_state == mpps_pkg::ST_CALC);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            mpps_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (ctl),
                .i_aik (r_aik),
                .i_bkj (rowk[g]),
                .o_best(best[g])
            );
        end
    endgenerate

    // Row read port: registered read of one row.
    logic [W-1:0] rd_row;
    logic [N*17-1:0] r_rd;
    always_comb begin
        if (r_state == mpps_pkg::ST_EMIT) rd_row = r_row;
        else rd_row = r_k;
    end

    logic [N*17-1:0] wr_data;
    logic            wr_en;
    logic [W-1:0]    wr_row;
    // Products go to a shadow bank so the current pass reads old values.
    logic [N*17-1:0] r_prod [N];

    always_comb begin
        wr_data = '0;
        for (int j = 0; j < N; j++) wr_data[j*17 +: 17] = best[j];
        wr_en = (r_state == mpps_pkg::ST_WRITE);
        wr_row = r_row;
    end

    logic [N*17-1:0] load_row;
    always_comb begin
        load_row = r_mat[r_row];
        load_row[r_col*17 +: 17] = wval;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mat[rd_row];
        if (in_acc) r_mat[r_row] <= load_row;
        if (wr_en) r_prod[wr_row] <= wr_data;
        if (r_state == mpps_pkg::ST_FETCH) r_aik <= r_mat[r_row][r_k*17 +: 17];
        if ((r_state == mpps_pkg::ST_WRITE) && (r_row == nlast)) begin
            for (int i = 0; i < N; i++) begin
                if (W'(i) != r_row) r_mat[i] <= r_prod[i];
                else r_mat[i] <= wr_data;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            rowk[j] = r_rd[j*17 +: 17];
        end
    end

    logic r_emit_ok;
    mpps_pkg::t_dist cur;
    assign cur = rowk[r_col];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpps_pkg::ST_LOAD;
            r_ncfg <= 4'd8;
            r_row <= '0; r_col <= '0; r_k <= '0;
            r_pass <= '0; r_passes <= '0;
            o_out_valid <= 1'b0;
            r_emit_ok <= 1'b0;
        end else begin
            // The emit branch below reloads the output register when it sends.
            if (out_acc && !((r_state == mpps_pkg::ST_EMIT) && r_emit_ok)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                mpps_pkg::ST_LOAD: begin
                    if (i_cfg_we) begin
                        r_ncfg <= i_cfg_data;
                        r_row <= '0; r_col <= '0;
                    end else if (in_acc) begin
                        if (r_col == nlast) begin
                            r_col <= '0;
                            if (r_row == nlast) begin
                                r_row <= '0; r_k <= '0; r_pass <= '0;
                                r_passes <= passes_calc;
                                r_emit_ok <= 1'b0;
                                if (passes_calc == 3'd0) r_state <= mpps_pkg::ST_EMIT;
                                else r_state <= mpps_pkg::ST_FETCH;
                            end else r_row <= r_row + 1'b1;
                        end else r_col <= r_col + 1'b1;
                    end
                end
                mpps_pkg::ST_FETCH: r_state <= mpps_pkg::ST_CALC;
                mpps_pkg::ST_CALC: begin
                    if (r_k == nlast) begin
                        r_k <= '0;
                        r_state <= mpps_pkg::ST_WRITE;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= mpps_pkg::ST_FETCH;
                    end
                end
                mpps_pkg::ST_WRITE: begin
                    r_state <= mpps_pkg::ST_FETCH;
                    if (r_row == nlast) begin
                        r_row <= '0;
                        if (r_pass + 3'd1 == r_passes) r_state <= mpps_pkg::ST_EMIT;
                        r_pass <= r_pass + 3'd1;
                    end else r_row <= r_row + 1'b1;
                end
                mpps_pkg::ST_EMIT: begin
                    // The registered row read comes first; then beats leave one per cycle when not stalled.
                    if (!r_emit_ok) begin
                        r_emit_ok <= 1'b1;
                    end else if (!o_out_valid || out_acc) begin
                        o_out_valid <= 1'b1;
                        o_distance <= (cur >= mpps_pkg::InfValue) ? 16'd0 : cur[15:0];
                        o_last <= (r_row == nlast) && (r_col == nlast);
                        if (r_col == nlast) begin
                            r_col <= '0;
                            r_emit_ok <= 1'b0;
                            if (r_row == nlast) begin
                                r_row <= '0;
                                r_state <= mpps_pkg::ST_LOAD;
                            end else r_row <= r_row + 1'b1;
                        end else r_col <= r_col + 1'b1;
                    end
                end
                default: r_state <= mpps_pkg::ST_LOAD;
            endcase
        end
    end
endmodule
